### sv/sfa_pkg.sv
// Shared widths, payload types and register codes of the separation force accumulator.
package sfa_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int ACC_WIDTH   = 48;

    localparam int RADIUS_W   = 31;
    localparam int FALLBACK_W = 18;
    localparam int OUT_W      = 32;
    localparam int NEAR_LIMIT = 7;

    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int MUL_W  = DIFF_W;
    localparam int PROD_W = 2 * MUL_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int ROOT_W = SUM_W / 2;
    localparam int CMP_W  = ROOT_W + 2;
    localparam int DVD_W  = ROOT_W + FRAC_BITS;
    localparam int UNIT_W = FRAC_BITS + 1;
    localparam int LO_W   = MUL_W - 1;
    localparam int HI_W   = DVD_W - LO_W;
    localparam int TOT_W  = UNIT_W + DVD_W;
    localparam int TM_W   = TOT_W - FRAC_BITS;
    localparam int CNT_W  = $clog2(DVD_W + 1);
    localparam int CFG_W  = 3;
    localparam int DATA_W = 32;

    typedef enum logic [CFG_W-1:0] {
        CFG_RADIUS = 3'd0,
        CFG_SELF_X = 3'd1,
        CFG_SELF_Y = 3'd2,
        CFG_SELF_Z = 3'd3,
        CFG_FB_X   = 3'd4,
        CFG_FB_Z   = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] nbr_x;
        logic signed [COORD_WIDTH-1:0] nbr_y;
        logic signed [COORD_WIDTH-1:0] nbr_z;
        logic                          nbr_present;
        logic                          last_nbr;
    } in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] force_x;
        logic signed [OUT_W-1:0] force_y;
        logic signed [OUT_W-1:0] force_z;
        logic                    force_saturated;
    } out_t;

endpackage

### sv/sfa_alu.sv
// Shared arithmetic unit: compare-subtract step for root and division, and one multiplier.
module sfa_alu (
    input  logic [sfa_pkg::CMP_W-1:0]  cmp_a,
    input  logic [sfa_pkg::CMP_W-1:0]  cmp_b,
    output logic                       cmp_ge,
    output logic [sfa_pkg::CMP_W-1:0]  cmp_diff,
    input  logic [sfa_pkg::MUL_W-1:0]  mul_a,
    input  logic [sfa_pkg::MUL_W-1:0]  mul_b,
    output logic [sfa_pkg::PROD_W-1:0] mul_p
);

    logic [sfa_pkg::CMP_W:0] sub;

    always_comb begin
        sub      = {1'b0, cmp_a} - {1'b0, cmp_b};
        cmp_ge   = ~sub[sfa_pkg::CMP_W];
        cmp_diff = sub[sfa_pkg::CMP_W-1:0];
        mul_p    = sfa_pkg::PROD_W'(mul_a) * sfa_pkg::PROD_W'(mul_b);
    end

endmodule

### sv/separation_force_accumulator.sv
// Top level: config registers, sequencer and accumulators of the separation force block.
//
//  channel | ports                        | payload
//  input   | s_valid s_ready s_data       | sfa_pkg::in_t
//  result  | m_valid m_ready m_data       | sfa_pkg::out_t
//  config  | cfg_valid cfg_ready cfg_index| cfg_data, always ready
//
// A present neighbor is accepted, then takes the squares, the root steps, the near test,
// the steps dividing by the radius and the strength, then per axis the division steps,
// two multiplies, add, sign and accumulate.
// A neighbor nearer than NEAR_LIMIT ends after the near test; an empty item on accept.
// A last beat adds an emit state.
// Reset is synchronous, active low; no clearing pass. A last beat waits in its
// emit cycle while the previous result is still untaken.
module separation_force_accumulator (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  sfa_pkg::in_t                s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output sfa_pkg::out_t               m_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [sfa_pkg::CFG_W-1:0]   cfg_index,
    input  logic [sfa_pkg::DATA_W-1:0]  cfg_data
);

    localparam int AW = sfa_pkg::ACC_WIDTH;
    localparam int CW = sfa_pkg::TM_W + AW;
    localparam logic signed [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
    localparam logic signed [AW-1:0] ACC_MIN = ~ACC_MAX;
    localparam logic [AW-1:0] ACC_MAX_U = {1'b0, {(AW-1){1'b1}}};
    localparam logic signed [AW-1:0] OUT_MAX =
        {{(AW-sfa_pkg::OUT_W+1){1'b0}}, {(sfa_pkg::OUT_W-1){1'b1}}};
    localparam logic signed [AW-1:0] OUT_MIN = ~OUT_MAX;
    localparam logic [sfa_pkg::DVD_W-1:0] ONE = sfa_pkg::DVD_W'(1) << sfa_pkg::FRAC_BITS;

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_SQ   = 13'b0000000000010,
        S_SQRT = 13'b0000000000100,
        S_NEAR = 13'b0000000001000,
        S_DIVS = 13'b0000000010000,
        S_STR  = 13'b0000000100000,
        S_DIVU = 13'b0000001000000,
        S_MLO  = 13'b0000010000000,
        S_MHI  = 13'b0000100000000,
        S_ADDP = 13'b0001000000000,
        S_TERM = 13'b0010000000000,
        S_ACC  = 13'b0100000000000,
        S_EMIT = 13'b1000000000000
    } state_t;

    function automatic logic signed [AW-1:0] sat_add(logic signed [AW-1:0] a,
                                                     logic signed [AW-1:0] b);
        logic signed [AW:0] s;
        s = {a[AW-1], a} + {b[AW-1], b};
        if (s[AW] != s[AW-1]) begin
            return s[AW] ? ACC_MIN : ACC_MAX;
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [sfa_pkg::DIFF_W-1:0] mag(logic signed [sfa_pkg::DIFF_W-1:0] v);
        return v[sfa_pkg::DIFF_W-1] ? sfa_pkg::DIFF_W'(-v) : sfa_pkg::DIFF_W'(v);
    endfunction

    state_t state_reg, state_next;
    logic [sfa_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0] axis_reg, axis_next;
    logic last_reg, last_next;

    logic [sfa_pkg::RADIUS_W-1:0] radius_reg;
    logic signed [sfa_pkg::COORD_WIDTH-1:0] self_x_reg, self_y_reg, self_z_reg;
    logic signed [sfa_pkg::FALLBACK_W-1:0] fb_x_reg, fb_z_reg;

    logic signed [sfa_pkg::DIFF_W-1:0] a_reg [0:2];
    logic signed [sfa_pkg::DIFF_W-1:0] a_next [0:2];
    logic signed [AW-1:0] sum_reg [0:2];
    logic signed [AW-1:0] sum_next [0:2];

    logic [sfa_pkg::SUM_W-1:0]  rad_reg, rad_next;
    logic [sfa_pkg::ROOT_W-1:0] root_reg, root_next;
    logic [sfa_pkg::CMP_W-1:0]  rem_reg, rem_next;
    logic [sfa_pkg::CMP_W-1:0]  dv_reg, dv_next;
    logic [sfa_pkg::DVD_W-1:0]  dvd_reg, dvd_next;
    logic [sfa_pkg::DVD_W-1:0]  quo_reg, quo_next;
    logic [sfa_pkg::DVD_W-1:0]  str_reg, str_next;
    logic str_neg_reg, str_neg_next;
    logic [sfa_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [sfa_pkg::TOT_W-1:0]  tot_reg, tot_next;
    logic signed [AW-1:0] term_reg, term_next;

    logic m_valid_reg, m_valid_next;
    sfa_pkg::out_t m_data_reg, m_data_next;

    logic [sfa_pkg::CMP_W-1:0]  cmp_a, cmp_b, cmp_diff;
    logic                       cmp_ge;
    logic [sfa_pkg::MUL_W-1:0]  mul_a, mul_b;
    logic [sfa_pkg::PROD_W-1:0] mul_p;

    logic [sfa_pkg::DIFF_W-1:0] am_str, am_nxt;
    logic [sfa_pkg::TM_W-1:0]   tm;
    logic [AW-1:0]              tsat;
    logic                       tneg, osat;
    logic signed [AW-1:0]       clip [0:2];

    sfa_alu u_alu (
        .cmp_a    (cmp_a),
        .cmp_b    (cmp_b),
        .cmp_ge   (cmp_ge),
        .cmp_diff (cmp_diff),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .mul_p    (mul_p)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_comb begin
        am_str = mag(a_reg[0]);
        am_nxt = mag(a_reg[(axis_reg == 2'd0) ? 2'd1 : 2'd2]);
        tm = tot_reg[sfa_pkg::TOT_W-1:sfa_pkg::FRAC_BITS];
        tsat = (CW'(tm) > CW'(ACC_MAX_U)) ? ACC_MAX_U : AW'(tm);
        tneg = (a_reg[axis_reg][sfa_pkg::DIFF_W-1] && (quo_reg != '0)) != str_neg_reg;
        osat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (sum_reg[i] > OUT_MAX) begin
                clip[i] = OUT_MAX;
                osat = 1'b1;
            end else if (sum_reg[i] < OUT_MIN) begin
                clip[i] = OUT_MIN;
                osat = 1'b1;
            end else begin
                clip[i] = sum_reg[i];
            end
        end

        cmp_a = '0;
        cmp_b = dv_reg;
        if (state_reg == S_SQRT) begin
            cmp_a = {rem_reg[sfa_pkg::CMP_W-3:0], rad_reg[sfa_pkg::SUM_W-1 -: 2]};
            cmp_b = {root_reg, 2'b01};
        end else begin
            cmp_a = {rem_reg[sfa_pkg::CMP_W-2:0], dvd_reg[sfa_pkg::DVD_W-1]};
        end

        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SQ: begin
                if (cnt_reg < sfa_pkg::CNT_W'(3)) begin
                    mul_a = mag(a_reg[cnt_reg[1:0]]);
                    mul_b = mul_a;
                end
            end
            S_MLO: begin
                mul_a = sfa_pkg::MUL_W'(quo_reg[sfa_pkg::UNIT_W-1:0]);
                mul_b = sfa_pkg::MUL_W'(str_reg[sfa_pkg::LO_W-1:0]);
            end
            S_MHI: begin
                mul_a = sfa_pkg::MUL_W'(quo_reg[sfa_pkg::UNIT_W-1:0]);
                mul_b = sfa_pkg::MUL_W'(str_reg[sfa_pkg::DVD_W-1:sfa_pkg::LO_W]);
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        axis_next    = axis_reg;
        last_next    = last_reg;
        a_next       = a_reg;
        sum_next     = sum_reg;
        rad_next     = rad_reg;
        root_next    = root_reg;
        rem_next     = rem_reg;
        dv_next      = dv_reg;
        dvd_next     = dvd_reg;
        quo_next     = quo_reg;
        str_next     = str_reg;
        str_neg_next = str_neg_reg;
        prod_next    = prod_reg;
        tot_next     = tot_reg;
        term_next    = term_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    last_next = s_data.last_nbr;
                    a_next[0] = sfa_pkg::DIFF_W'(self_x_reg) - sfa_pkg::DIFF_W'(s_data.nbr_x);
                    a_next[1] = sfa_pkg::DIFF_W'(self_y_reg) - sfa_pkg::DIFF_W'(s_data.nbr_y);
                    a_next[2] = sfa_pkg::DIFF_W'(self_z_reg) - sfa_pkg::DIFF_W'(s_data.nbr_z);
                    cnt_next  = '0;
                    if (s_data.nbr_present) begin
                        state_next = S_SQ;
                    end else if (s_data.last_nbr) begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_SQ: begin
                prod_next = mul_p;
                if (cnt_reg == '0) begin
                    rad_next = '0;
                end else begin
                    rad_next = rad_reg + sfa_pkg::SUM_W'(prod_reg);
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == sfa_pkg::CNT_W'(3)) begin
                    cnt_next   = '0;
                    rem_next   = '0;
                    root_next  = '0;
                    state_next = S_SQRT;
                end
            end
            S_SQRT: begin
                rem_next  = cmp_ge ? cmp_diff : cmp_a;
                root_next = {root_reg[sfa_pkg::ROOT_W-2:0], cmp_ge};
                rad_next  = rad_reg << 2;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == sfa_pkg::CNT_W'(sfa_pkg::ROOT_W - 1)) begin
                    state_next = S_NEAR;
                end
            end
            S_NEAR: begin
                if (root_reg < sfa_pkg::ROOT_W'(sfa_pkg::NEAR_LIMIT)) begin
                    sum_next[0] = sat_add(sum_reg[0], AW'(fb_x_reg));
                    sum_next[2] = sat_add(sum_reg[2], AW'(fb_z_reg));
                    state_next  = last_reg ? S_EMIT : S_IDLE;
                end else begin
                    rem_next   = '0;
                    quo_next   = '0;
                    cnt_next   = '0;
                    dvd_next   = {root_reg, {sfa_pkg::FRAC_BITS{1'b0}}};
                    dv_next    = (radius_reg == '0) ? sfa_pkg::CMP_W'(1)
                                                    : sfa_pkg::CMP_W'(radius_reg);
                    state_next = S_DIVS;
                end
            end
            S_DIVS, S_DIVU: begin
                rem_next = cmp_ge ? cmp_diff : cmp_a;
                quo_next = {quo_reg[sfa_pkg::DVD_W-2:0], cmp_ge};
                dvd_next = dvd_reg << 1;
                cnt_next = cnt_reg + 1'b1;
                if (state_reg == S_DIVS) begin
                    if (cnt_reg == sfa_pkg::CNT_W'(sfa_pkg::DVD_W - 1)) begin
                        state_next = S_STR;
                    end
                end else if (cnt_reg == sfa_pkg::CNT_W'(sfa_pkg::UNIT_W - 1)) begin
                    state_next = S_MLO;
                end
            end
            S_STR: begin
                str_neg_next = quo_reg > ONE;
                str_next     = (quo_reg > ONE) ? quo_reg - ONE : ONE - quo_reg;
                axis_next    = 2'd0;
                state_next   = S_DIVU;
                rem_next     = sfa_pkg::CMP_W'(am_str >> 1);
                dvd_next     = {am_str[0], {(sfa_pkg::DVD_W-1){1'b0}}};
                dv_next      = sfa_pkg::CMP_W'(root_reg);
                quo_next     = '0;
                cnt_next     = '0;
            end
            S_MLO: begin
                prod_next  = mul_p;
                state_next = S_MHI;
            end
            S_MHI: begin
                prod_next  = mul_p;
                tot_next   = sfa_pkg::TOT_W'(prod_reg);
                state_next = S_ADDP;
            end
            S_ADDP: begin
                tot_next   = tot_reg + sfa_pkg::TOT_W'({prod_reg, {sfa_pkg::LO_W{1'b0}}});
                state_next = S_TERM;
            end
            S_TERM: begin
                term_next  = tneg ? -$signed(tsat) : $signed(tsat);
                state_next = S_ACC;
            end
            S_ACC: begin
                sum_next[axis_reg] = sat_add(sum_reg[axis_reg], term_reg);
                if (axis_reg == 2'd2) begin
                    state_next = last_reg ? S_EMIT : S_IDLE;
                end else begin
                    axis_next  = axis_reg + 1'b1;
                    rem_next   = sfa_pkg::CMP_W'(am_nxt >> 1);
                    dvd_next   = {am_nxt[0], {(sfa_pkg::DVD_W-1){1'b0}}};
                    quo_next   = '0;
                    cnt_next   = '0;
                    state_next = S_DIVU;
                end
            end
            S_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next.force_x         = clip[0][sfa_pkg::OUT_W-1:0];
                    m_data_next.force_y         = clip[1][sfa_pkg::OUT_W-1:0];
                    m_data_next.force_z         = clip[2][sfa_pkg::OUT_W-1:0];
                    m_data_next.force_saturated = osat;
                    m_valid_next = 1'b1;
                    sum_next[0]  = '0;
                    sum_next[1]  = '0;
                    sum_next[2]  = '0;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            axis_reg    <= '0;
            last_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            radius_reg  <= sfa_pkg::RADIUS_W'(65536);
            self_x_reg  <= '0;
            self_y_reg  <= '0;
            self_z_reg  <= '0;
            fb_x_reg    <= sfa_pkg::FALLBACK_W'(65536);
            fb_z_reg    <= '0;
            for (int i = 0; i < 3; i++) begin
                sum_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            axis_reg    <= axis_next;
            last_reg    <= last_next;
            m_valid_reg <= m_valid_next;
            sum_reg     <= sum_next;
            if (cfg_valid) begin
                case (cfg_index)
                    sfa_pkg::CFG_RADIUS: radius_reg <= cfg_data[sfa_pkg::RADIUS_W-1:0];
                    sfa_pkg::CFG_SELF_X: self_x_reg <= cfg_data;
                    sfa_pkg::CFG_SELF_Y: self_y_reg <= cfg_data;
                    sfa_pkg::CFG_SELF_Z: self_z_reg <= cfg_data;
                    sfa_pkg::CFG_FB_X:   fb_x_reg   <= cfg_data[sfa_pkg::FALLBACK_W-1:0];
                    sfa_pkg::CFG_FB_Z:   fb_z_reg   <= cfg_data[sfa_pkg::FALLBACK_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        a_reg       <= a_next;
        rad_reg     <= rad_next;
        root_reg    <= root_next;
        rem_reg     <= rem_next;
        dv_reg      <= dv_next;
        dvd_reg     <= dvd_next;
        quo_reg     <= quo_next;
        str_reg     <= str_next;
        str_neg_reg <= str_neg_next;
        prod_reg    <= prod_next;
        tot_reg     <= tot_next;
        term_reg    <= term_next;
        m_data_reg  <= m_data_next;
    end

endmodule

### sim/testbench.sv
// Self-checking testbench of the separation force accumulator: predicted forces versus block output.
module testbench;

    localparam int MAX_CYCLES = 2_000_000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    sfa_pkg::in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    sfa_pkg::out_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [sfa_pkg::CFG_W-1:0] cfg_index = '0;
    logic [sfa_pkg::DATA_W-1:0] cfg_data = '0;

    separation_force_accumulator i_dut (.*);

    always #6 aclk = ~aclk;

    // predictor state
    logic [30:0] radius_reg;
    logic signed [31:0] self_xr, self_yr, self_zr;
    logic signed [17:0] fb_xr, fb_zr;
    logic signed [47:0] acc_x, acc_y, acc_z;

    sfa_pkg::out_t force_queue[$];
    int error_count = 0;
    int hold_off = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        error_count++;
    endtask

    function automatic logic signed [47:0] acc_add(input logic signed [47:0] a,
                                                    input logic signed [63:0] b);
        logic signed [63:0] s;
        s = 64'(a) + b;
        if (s > 64'sh7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
        if (s < -64'sh8000_0000_0000) return -48'sh8000_0000_0000;
        return s[47:0];
    endfunction

    function automatic logic signed [63:0] axis_term(input logic signed [63:0] a,
                                                      input logic [63:0] d,
                                                      input logic signed [63:0] str);
        logic [63:0] ma, ms, q;
        logic [127:0] p;
        logic neg;
        ma = a < 0 ? -a : a;
        q = (ma << sfa_pkg::FRAC_BITS) / d;
        ms = str < 0 ? -str : str;
        p = (128'(q) * 128'(ms)) >> sfa_pkg::FRAC_BITS;
        neg = (a < 0) != (str < 0) && q != 0;
        if (p > 128'h7FFF_FFFF_FFFF) p = 128'h7FFF_FFFF_FFFF;
        return neg ? -$signed(64'(p)) : $signed(64'(p));
    endfunction

    function automatic logic [31:0] clip(input logic signed [47:0] v, inout logic sat);
        if (v > 48'sh7FFF_FFFF) begin sat = 1'b1; return 32'h7FFF_FFFF; end
        if (v < -48'sh8000_0000) begin sat = 1'b1; return 32'h8000_0000; end
        return v[31:0];
    endfunction

    task automatic predict_force(input sfa_pkg::in_t it);
        logic signed [63:0] ax, ay, az, str;
        logic [127:0] sq, t2;
        logic [63:0] d, t, rad;
        logic sat;
        sfa_pkg::out_t r;
        if (it.nbr_present) begin
            ax = 64'(self_xr) - 64'(it.nbr_x);
            ay = 64'(self_yr) - 64'(it.nbr_y);
            az = 64'(self_zr) - 64'(it.nbr_z);
            sq = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay) + 128'(az) * 128'(az);
            d = 0;
            for (int b = 63; b >= 0; b--) begin
                t = d | (64'd1 << b);
                t2 = 128'(t) * 128'(t);
                if (t2 <= sq) d = t;
            end
            rad = radius_reg == 0 ? 64'd1 : 64'(radius_reg);
            if (d < sfa_pkg::NEAR_LIMIT) begin
                acc_x = acc_add(acc_x, 64'(fb_xr));
                acc_z = acc_add(acc_z, 64'(fb_zr));
            end else begin
                str = 64'sd65536 - $signed((d << sfa_pkg::FRAC_BITS) / rad);
                acc_x = acc_add(acc_x, axis_term(ax, d, str));
                acc_y = acc_add(acc_y, axis_term(ay, d, str));
                acc_z = acc_add(acc_z, axis_term(az, d, str));
            end
        end
        if (it.last_nbr) begin
            sat = 1'b0;
            r.force_x = clip(acc_x, sat);
            r.force_y = clip(acc_y, sat);
            r.force_z = clip(acc_z, sat);
            r.force_saturated = sat;
            force_queue.push_back(r);
            acc_x = '0; acc_y = '0; acc_z = '0;
        end
    endtask

    task automatic random_gap();
        int n;
        n = $urandom_range(0, 99);
        if (n < 60) n = 0;
        else if (n < 95) n = $urandom_range(1, 3);
        else n = $urandom_range(10, 60);
        repeat (n) @(negedge aclk);
    endtask

    task automatic send_item(input sfa_pkg::in_t it);
        s_data = it;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        predict_force(it);
        @(negedge aclk);
        s_valid = 1'b0;
        random_gap();
    endtask

    task automatic send_nbr(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
                            input logic present, input logic last);
        sfa_pkg::in_t it;
        it.nbr_x = x; it.nbr_y = y; it.nbr_z = z;
        it.nbr_present = present; it.last_nbr = last;
        send_item(it);
    endtask

    task automatic wait_drain();
        int guard;
        guard = 0;
        while (force_queue.size() != 0 && guard < 200000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (200) @(negedge aclk);
    endtask

    task automatic write_reg(input sfa_pkg::cfg_idx_t idx, input logic [31:0] value);
        cfg_index = idx;
        cfg_data = value;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            sfa_pkg::CFG_RADIUS: radius_reg = value[30:0];
            sfa_pkg::CFG_SELF_X: self_xr = value;
            sfa_pkg::CFG_SELF_Y: self_yr = value;
            sfa_pkg::CFG_SELF_Z: self_zr = value;
            sfa_pkg::CFG_FB_X:   fb_xr = value[17:0];
            sfa_pkg::CFG_FB_Z:   fb_zr = value[17:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_agent(input logic [31:0] rad, input logic [31:0] sx,
                             input logic [31:0] sy, input logic [31:0] sz,
                             input logic [31:0] fx, input logic [31:0] fz);
        wait_drain();
        write_reg(sfa_pkg::CFG_RADIUS, rad);
        write_reg(sfa_pkg::CFG_SELF_X, sx);
        write_reg(sfa_pkg::CFG_SELF_Y, sy);
        write_reg(sfa_pkg::CFG_SELF_Z, sz);
        write_reg(sfa_pkg::CFG_FB_X, fx);
        write_reg(sfa_pkg::CFG_FB_Z, fz);
    endtask

    function automatic logic [31:0] near_coord(input logic [31:0] c);
        case ($urandom_range(0, 3))
            0: return c + $urandom_range(0, 6) - 3;
            1: return c + $urandom_range(0, 32'h3_0000) - 32'h1_8000;
            2: return c + $urandom() % 32'h40_0000 - 32'h20_0000;
            default: return $urandom();
        endcase
    endfunction

    task automatic test_directed();
        send_nbr(0, 0, 0, 1'b0, 1'b1);
        send_nbr(0, 0, 0, 1'b1, 1'b1);
        send_nbr(3, 0, 0, 1'b1, 1'b0);
        send_nbr(32'h8000, 0, 0, 1'b1, 1'b1);
        send_nbr(0, 32'h8000, 32'h8000, 1'b1, 1'b0);
        send_nbr(32'h2_0000, 0, 0, 1'b1, 1'b1);
        send_nbr(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1);
        send_nbr(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1);
        send_nbr(32'hFFFF_FFFF, 0, 32'h7, 1'b1, 1'b0);
        send_nbr(32'h1234_5678, 32'h8765_4321, 0, 1'b0, 1'b1);
        set_agent(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h3_0000, 32'h1_0000);
        send_nbr(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b1);
        send_nbr(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1);
        set_agent(32'h0, 32'h100, 32'hFFFF_FF00, 0, 32'h3_FFFF, 32'h2_0000);
        for (int i = 0; i < 4; i++) send_nbr(32'h100, 32'hFFFF_FF00, 32'h2, 1'b1, 1'b0);
        send_nbr(32'h8000_0000, 0, 0, 1'b1, 1'b0);
        send_nbr(32'h7FFF_FFFF, 0, 0, 1'b1, 1'b1);
        set_agent(32'h1, 0, 0, 0, 32'h1_0000, 32'h3_0000);
        send_nbr(32'h100, 0, 0, 1'b1, 1'b1);
        send_nbr(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b1);
    endtask

    task automatic test_random(input int count);
        logic [31:0] sx, sy, sz;
        int sent;
        sent = 0;
        while (sent < count) begin
            set_agent($urandom_range(0, 9) == 0 ? $urandom() : $urandom_range(1, 32'h40_0000),
                      $urandom(), $urandom(), $urandom(),
                      $urandom_range(0, 32'h3_FFFF), $urandom_range(0, 32'h3_FFFF));
            sx = self_xr; sy = self_yr; sz = self_zr;
            for (int k = 0; k < 150; k++) begin
                send_nbr(near_coord(sx), near_coord(sy), near_coord(sz),
                         $urandom_range(0, 7) != 0, $urandom_range(0, 3) == 0);
                sent++;
            end
        end
    endtask

    task automatic test_backpressure();
        hold_off = 400;
        for (int k = 0; k < 12; k++)
            send_nbr($urandom(), $urandom(), $urandom(), 1'b1, 1'b1);
        wait_drain();
        send_nbr(0, 0, 0, 1'b0, 1'b1);
    endtask

    initial begin
        radius_reg = 31'd65536;
        self_xr = '0; self_yr = '0; self_zr = '0;
        fb_xr = 18'sd65536; fb_zr = '0;
        acc_x = '0; acc_y = '0; acc_z = '0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_backpressure();
        test_random(1200);
        wait_drain();
        if (error_count == 0 && force_queue.size() == 0) begin
            $display("[separation_force_accumulator] OK");
        end else begin
            $display("[separation_force_accumulator] ERROR");
        end
        $finish;
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= $urandom_range(0, 9) < 7;
        end
    end

    always @(posedge aclk) begin
        sfa_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (force_queue.size() == 0) begin
                report("unexpected beat", m_data.force_x, 32'd0);
            end else begin
                want = force_queue.pop_front();
                if (m_data.force_x !== want.force_x)
                    report("force_x", m_data.force_x, want.force_x);
                if (m_data.force_y !== want.force_y)
                    report("force_y", m_data.force_y, want.force_y);
                if (m_data.force_z !== want.force_z)
                    report("force_z", m_data.force_z, want.force_z);
                if (m_data.force_saturated !== want.force_saturated)
                    report("force_saturated", 32'(m_data.force_saturated),
                           32'(want.force_saturated));
            end
        end
    end

    initial begin
        repeat (MAX_CYCLES) @(posedge aclk);
        $display("[separation_force_accumulator] ERROR");
        $finish;
    end

endmodule
